// ===== rtl/icdfa_enumerator_assert.svh =====
// ---------------------------------------------------------------------------
// icdfa_enumerator_assert.svh
// Assertion macros for the enumerator block.
// ---------------------------------------------------------------------------
`ifndef ICDFA_ENUMERATOR_ASSERT_SVH
`define ICDFA_ENUMERATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define ICDFA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define ICDFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ICDFA_ASSERT_SAME(lbl, ante, cons, msg)
`define ICDFA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/icdfa_pkg.sv =====
// ---------------------------------------------------------------------------
// icdfa_pkg
// Sizes, codes and control types shared by the enumerator modules.
// ---------------------------------------------------------------------------
package icdfa_pkg;
    localparam int MAX_STATES  = 8;
    localparam int MAX_SYMBOLS = 8;
    localparam int DEPTH       = MAX_STATES * MAX_SYMBOLS;
    localparam int AW          = $clog2(DEPTH);
    localparam int TW          = AW + 1;
    localparam int SW          = $clog2(MAX_STATES);
    localparam int NF          = MAX_STATES - 1;
    localparam int CW          = 4;
    localparam int IW          = 8;

    localparam logic [IW-1:0] REG_NUM_STATES  = IW'(0);
    localparam logic [IW-1:0] REG_NUM_SYMBOLS = IW'(1);

    typedef enum logic [3:0] {
        ST_INIT_LOAD,
        ST_INIT_SWEEP,
        ST_IDLE,
        ST_DECIDE,
        ST_LOAD_SWEEP,
        ST_ODO_RD,
        ST_ODO_WR,
        ST_FULL_RD,
        ST_FULL_CK,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_WAIT
    } state_t;

    typedef struct packed {
        logic cfg_write;
        logic capture;
        logic load_flags;
        logic advance_flags;
        logic ptr_zero;
        logic ptr_top;
        logic ptr_inc;
        logic ptr_dec;
        logic sweep_wr;
        logic odo_wr;
        logic status_clr;
        logic full_set;
        logic full_chk;
        logic out_load;
        logic out_pop;
    } cmd_t;

    typedef struct packed {
        logic ptr_last;
        logic ptr_zero;
        logic restart;
        logic full_tab;
        logic final_tab;
        logic odo_stop;
        logic cfg_hit;
    } status_t;
endpackage

// ===== rtl/icdfa_enumerator.sv =====
// ---------------------------------------------------------------------------
// icdfa_enumerator
// Steps through initially connected DFA transition tables in canonical order
// and streams each table entry by entry.
// ---------------------------------------------------------------------------
// channel  dir  handshake              payload
// s_       in   s_valid / s_ready      s_restart
// m_       out  m_valid / m_ready      entry_index, target_state, full, final, last
// cfg_     in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// T = num_states * num_symbols. A decide state follows each accepted item.
// Restart, last-table wrap or flag move: a table load sweep over T entries,
// then each item passes read, load and wait states. Odometer advance: a read
// and a write step per slot visited by the carry, a fullness scan over T entries,
// then streaming. After reset and after each size write, a table load runs before
// items are accepted. One item is worked at a time; a stalled m_ready holds it.
`include "icdfa_enumerator_assert.svh"
module icdfa_enumerator (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_restart,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [icdfa_pkg::AW-1:0]      m_entry_index,
    output logic [icdfa_pkg::SW-1:0]      m_target_state,
    output logic                          m_table_full,
    output logic                          m_table_final,
    output logic                          m_run_last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [icdfa_pkg::IW-1:0]      cfg_index,
    input  logic [icdfa_pkg::CW-1:0]      cfg_data
);
    icdfa_pkg::cmd_t    cmd;
    icdfa_pkg::status_t sts;

    icdfa_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .cfg_valid (cfg_valid),
        .m_ready   (m_ready),
        .sts       (sts),
        .cmd       (cmd),
        .s_ready   (s_ready),
        .cfg_ready (cfg_ready)
    );

    icdfa_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_restart      (s_restart),
        .m_valid        (m_valid),
        .m_entry_index  (m_entry_index),
        .m_target_state (m_target_state),
        .m_table_full   (m_table_full),
        .m_table_final  (m_table_final),
        .m_run_last     (m_run_last)
    );

    `ICDFA_ASSERT_SAME(a_no_accept_while_out, m_valid, !s_ready && !cfg_ready, "accept during stream")
    `ICDFA_ASSERT_SAME(a_one_channel, s_ready, !cfg_valid, "item and write taken together")
    `ICDFA_ASSERT_NEXT(a_run_continues, m_valid && m_ready && !m_run_last, !s_ready, "run cut short")
    `ICDFA_ASSERT_NEXT(a_run_ends, m_valid && m_ready && m_run_last, cfg_ready, "no idle after run")
endmodule

// ===== rtl/icdfa_ram.sv =====
// ---------------------------------------------------------------------------
// icdfa_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module icdfa_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/icdfa_ctrl.sv =====
// ---------------------------------------------------------------------------
// icdfa_ctrl
// Sequencer: load sweeps, odometer step, fullness scan and table streaming.
// ---------------------------------------------------------------------------
module icdfa_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              cfg_valid,
    input  logic              m_ready,
    input  icdfa_pkg::status_t sts,
    output icdfa_pkg::cmd_t   cmd,
    output logic              s_ready,
    output logic              cfg_ready
);
    icdfa_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= icdfa_pkg::ST_INIT_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            icdfa_pkg::ST_INIT_LOAD:  state_next = icdfa_pkg::ST_INIT_SWEEP;
            icdfa_pkg::ST_INIT_SWEEP: begin
                if (sts.ptr_last) state_next = icdfa_pkg::ST_IDLE;
            end
            icdfa_pkg::ST_IDLE: begin
                if (cfg_valid) begin
                    if (sts.cfg_hit) state_next = icdfa_pkg::ST_INIT_LOAD;
                end else if (s_valid) begin
                    state_next = icdfa_pkg::ST_DECIDE;
                end
            end
            icdfa_pkg::ST_DECIDE: begin
                if (sts.restart || sts.final_tab || sts.full_tab) begin
                    state_next = icdfa_pkg::ST_LOAD_SWEEP;
                end else begin
                    state_next = icdfa_pkg::ST_ODO_RD;
                end
            end
            icdfa_pkg::ST_LOAD_SWEEP: begin
                if (sts.ptr_last) state_next = icdfa_pkg::ST_OUT_RD;
            end
            icdfa_pkg::ST_ODO_RD: state_next = icdfa_pkg::ST_ODO_WR;
            icdfa_pkg::ST_ODO_WR: begin
                if (sts.odo_stop || sts.ptr_zero) state_next = icdfa_pkg::ST_FULL_RD;
                else state_next = icdfa_pkg::ST_ODO_RD;
            end
            icdfa_pkg::ST_FULL_RD: state_next = icdfa_pkg::ST_FULL_CK;
            icdfa_pkg::ST_FULL_CK: begin
                if (sts.ptr_last) state_next = icdfa_pkg::ST_OUT_RD;
                else state_next = icdfa_pkg::ST_FULL_RD;
            end
            icdfa_pkg::ST_OUT_RD: state_next = icdfa_pkg::ST_OUT_LD;
            icdfa_pkg::ST_OUT_LD: state_next = icdfa_pkg::ST_OUT_WAIT;
            icdfa_pkg::ST_OUT_WAIT: begin
                if (m_ready) begin
                    if (sts.ptr_last) state_next = icdfa_pkg::ST_IDLE;
                    else state_next = icdfa_pkg::ST_OUT_RD;
                end
            end
            default: state_next = icdfa_pkg::ST_INIT_LOAD;
        endcase
    end

    always_comb begin
        cmd       = '0;
        s_ready   = 1'b0;
        cfg_ready = 1'b0;
        case (state_reg)
            icdfa_pkg::ST_INIT_LOAD: begin
                cmd.load_flags = 1'b1;
                cmd.ptr_zero   = 1'b1;
            end
            icdfa_pkg::ST_INIT_SWEEP, icdfa_pkg::ST_LOAD_SWEEP: begin
                cmd.sweep_wr   = 1'b1;
                cmd.status_clr = 1'b1;
                if (sts.ptr_last) cmd.ptr_zero = 1'b1;
                else cmd.ptr_inc = 1'b1;
            end
            icdfa_pkg::ST_IDLE: begin
                cfg_ready     = 1'b1;
                s_ready       = !cfg_valid;
                cmd.cfg_write = cfg_valid;
                cmd.capture   = !cfg_valid && s_valid;
            end
            icdfa_pkg::ST_DECIDE: begin
                if (sts.restart || sts.final_tab) begin
                    cmd.load_flags = 1'b1;
                    cmd.ptr_zero   = 1'b1;
                end else if (sts.full_tab) begin
                    cmd.advance_flags = 1'b1;
                    cmd.ptr_zero      = 1'b1;
                end else begin
                    cmd.ptr_top = 1'b1;
                end
            end
            icdfa_pkg::ST_ODO_WR: begin
                cmd.odo_wr = 1'b1;
                if (sts.odo_stop || sts.ptr_zero) begin
                    cmd.full_set = 1'b1;
                    cmd.ptr_zero = 1'b1;
                end else begin
                    cmd.ptr_dec = 1'b1;
                end
            end
            icdfa_pkg::ST_FULL_CK: begin
                cmd.full_chk = 1'b1;
                if (sts.ptr_last) cmd.ptr_zero = 1'b1;
                else cmd.ptr_inc = 1'b1;
            end
            icdfa_pkg::ST_OUT_LD: cmd.out_load = 1'b1;
            icdfa_pkg::ST_OUT_WAIT: begin
                if (m_ready) begin
                    cmd.out_pop = 1'b1;
                    if (!sts.ptr_last) cmd.ptr_inc = 1'b1;
                end
            end
            default: cmd = '0;
        endcase
    end
endmodule

// ===== rtl/icdfa_datapath.sv =====
// ---------------------------------------------------------------------------
// icdfa_datapath
// Size registers, flag positions, table RAM, scan pointer and result register.
// ---------------------------------------------------------------------------
module icdfa_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  icdfa_pkg::cmd_t               cmd,
    output icdfa_pkg::status_t            sts,
    input  logic [icdfa_pkg::IW-1:0]      cfg_index,
    input  logic [icdfa_pkg::CW-1:0]      cfg_data,
    input  logic                          s_restart,
    output logic                          m_valid,
    output logic [icdfa_pkg::AW-1:0]      m_entry_index,
    output logic [icdfa_pkg::SW-1:0]      m_target_state,
    output logic                          m_table_full,
    output logic                          m_table_final,
    output logic                          m_run_last
);
    logic [icdfa_pkg::CW-1:0] num_states_reg, num_symbols_reg;
    logic [icdfa_pkg::AW-1:0] flag_reg [icdfa_pkg::NF];
    logic [icdfa_pkg::AW-1:0] flag_next [icdfa_pkg::NF];
    logic [icdfa_pkg::AW-1:0] ptr_reg, ptr_next;
    logic                     restart_reg;
    logic                     full_reg, full_next;
    logic                     m_valid_reg;
    logic [icdfa_pkg::AW-1:0] out_index_reg;
    logic [icdfa_pkg::SW-1:0] out_target_reg;
    logic                     out_full_reg, out_final_reg, out_last_reg;

    logic [icdfa_pkg::CW-1:0]   n_use, k_use, nf_use;
    logic [2*icdfa_pkg::CW-1:0] prod;
    logic [icdfa_pkg::AW-1:0]   last_idx;
    logic [icdfa_pkg::SW-1:0]   cnt, rdata, sweep_val, odo_val, wdata;
    logic                       hit, first_ok, free, we, carry;

    always_comb begin
        if (num_states_reg < icdfa_pkg::CW'(2)) begin
            n_use = icdfa_pkg::CW'(2);
        end else if (num_states_reg > icdfa_pkg::CW'(icdfa_pkg::MAX_STATES)) begin
            n_use = icdfa_pkg::CW'(icdfa_pkg::MAX_STATES);
        end else begin
            n_use = num_states_reg;
        end
        if (num_symbols_reg < icdfa_pkg::CW'(1)) begin
            k_use = icdfa_pkg::CW'(1);
        end else if (num_symbols_reg > icdfa_pkg::CW'(icdfa_pkg::MAX_SYMBOLS)) begin
            k_use = icdfa_pkg::CW'(icdfa_pkg::MAX_SYMBOLS);
        end else begin
            k_use = num_symbols_reg;
        end
    end

    assign nf_use   = n_use - icdfa_pkg::CW'(1);
    assign prod     = {{icdfa_pkg::CW{1'b0}}, n_use} * {{icdfa_pkg::CW{1'b0}}, k_use};
    assign last_idx = icdfa_pkg::AW'(prod - (2*icdfa_pkg::CW)'(1));

    always_comb begin
        cnt      = '0;
        hit      = 1'b0;
        first_ok = 1'b1;
        for (int i = 0; i < icdfa_pkg::NF; i++) begin
            if (icdfa_pkg::CW'(i) < nf_use) begin
                if (flag_reg[i] < ptr_reg) cnt = cnt + icdfa_pkg::SW'(1);
                if (flag_reg[i] == ptr_reg) hit = 1'b1;
                if (flag_reg[i] != icdfa_pkg::AW'(i)) first_ok = 1'b0;
            end
        end
    end

    assign free      = !hit;
    assign sweep_val = hit ? cnt + icdfa_pkg::SW'(1) : '0;
    assign odo_val   = (rdata >= cnt) ? '0 : rdata + icdfa_pkg::SW'(1);
    assign we        = cmd.sweep_wr || (cmd.odo_wr && free);
    assign wdata     = cmd.sweep_wr ? sweep_val : odo_val;

    icdfa_ram #(.WIDTH(icdfa_pkg::SW), .DEPTH(icdfa_pkg::DEPTH)) u_table (
        .aclk  (aclk),
        .we    (we),
        .waddr (ptr_reg),
        .wdata (wdata),
        .raddr (ptr_reg),
        .rdata (rdata)
    );

    always_comb begin
        carry = 1'b1;
        for (int i = 0; i < icdfa_pkg::NF; i++) begin
            flag_next[i] = flag_reg[i];
        end
        if (cmd.load_flags) begin
            for (int i = 0; i < icdfa_pkg::NF; i++) begin
                flag_next[i] = icdfa_pkg::AW'(int'(k_use) * (i + 1) - 1);
            end
        end else if (cmd.advance_flags) begin
            for (int i = icdfa_pkg::NF - 1; i > 0; i--) begin
                if (icdfa_pkg::CW'(i) < nf_use && carry) begin
                    if (flag_reg[i] - icdfa_pkg::AW'(1) == flag_reg[i-1]) begin
                        flag_next[i] = icdfa_pkg::AW'(int'(k_use) * (i + 1) - 1);
                    end else begin
                        flag_next[i] = flag_reg[i] - icdfa_pkg::AW'(1);
                        carry        = 1'b0;
                    end
                end
            end
            if (carry && flag_reg[0] != '0) flag_next[0] = flag_reg[0] - icdfa_pkg::AW'(1);
        end
    end

    always_comb begin
        ptr_next = ptr_reg;
        if (cmd.ptr_zero) ptr_next = '0;
        else if (cmd.ptr_top) ptr_next = last_idx;
        else if (cmd.ptr_inc) ptr_next = ptr_reg + icdfa_pkg::AW'(1);
        else if (cmd.ptr_dec) ptr_next = ptr_reg - icdfa_pkg::AW'(1);
    end

    always_comb begin
        full_next = full_reg;
        if (cmd.status_clr) full_next = 1'b0;
        else if (cmd.full_set) full_next = 1'b1;
        else if (cmd.full_chk && free && rdata != cnt) full_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_states_reg  <= icdfa_pkg::CW'(2);
            num_symbols_reg <= icdfa_pkg::CW'(2);
            full_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
            ptr_reg         <= '0;
        end else begin
            if (cmd.cfg_write) begin
                case (cfg_index)
                    icdfa_pkg::REG_NUM_STATES:  num_states_reg  <= cfg_data;
                    icdfa_pkg::REG_NUM_SYMBOLS: num_symbols_reg <= cfg_data;
                    default: ;
                endcase
            end
            full_reg <= full_next;
            ptr_reg  <= ptr_next;
            if (cmd.out_load) m_valid_reg <= 1'b1;
            else if (cmd.out_pop) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < icdfa_pkg::NF; i++) begin
            flag_reg[i] <= flag_next[i];
        end
        if (cmd.capture) restart_reg <= s_restart;
        if (cmd.out_load) begin
            out_index_reg  <= ptr_reg;
            out_target_reg <= rdata;
            out_full_reg   <= full_reg;
            out_final_reg  <= first_ok && full_reg;
            out_last_reg   <= (ptr_reg == last_idx);
        end
    end

    assign sts.ptr_last  = (ptr_reg == last_idx);
    assign sts.ptr_zero  = (ptr_reg == '0);
    assign sts.restart   = restart_reg;
    assign sts.full_tab  = full_reg;
    assign sts.final_tab = first_ok && full_reg;
    assign sts.odo_stop  = free && (rdata < cnt);
    assign sts.cfg_hit   = (cfg_index == icdfa_pkg::REG_NUM_STATES)
                        || (cfg_index == icdfa_pkg::REG_NUM_SYMBOLS);

    assign m_valid        = m_valid_reg;
    assign m_entry_index  = out_index_reg;
    assign m_target_state = out_target_reg;
    assign m_table_full   = out_full_reg;
    assign m_table_final  = out_final_reg;
    assign m_run_last     = out_last_reg;
endmodule

// ===== sim/tb_icdfa_enumerator.sv =====
// ----------------------------------------------------------------------------
// tb_icdfa_enumerator
// Self-checking bench for the DFA table enumerator: a local model predicts
// every streamed table entry from restart/advance items and size writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_icdfa_enumerator;
    localparam int CYCLE_LIMIT = 2000000;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic                           s_restart = 1'b0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [icdfa_pkg::AW-1:0]       m_entry_index;
    logic [icdfa_pkg::SW-1:0]       m_target_state;
    logic                           m_table_full;
    logic                           m_table_final;
    logic                           m_run_last;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [icdfa_pkg::IW-1:0]       cfg_index = '0;
    logic [icdfa_pkg::CW-1:0]       cfg_data = '0;

    typedef struct packed {
        logic [icdfa_pkg::AW-1:0] idx;
        logic [icdfa_pkg::SW-1:0] tgt;
        logic                     full;
        logic                     fin;
        logic                     last;
    } entry_t;

    entry_t   entry_q[$];
    int       err_count;
    int       cycle_count;
    int       item_count;
    int       entry_count;
    bit       m_idle_on;
    int       m_wait;
    int       m_seen;

    logic [icdfa_pkg::CW-1:0] sz_states, sz_symbols;
    logic [icdfa_pkg::SW-1:0] tab[icdfa_pkg::DEPTH];
    int       flag[icdfa_pkg::NF];

    icdfa_enumerator DUT (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic int n_used();
        return sz_states < 2 ? 2 : (sz_states > icdfa_pkg::MAX_STATES ?
                                    icdfa_pkg::MAX_STATES : sz_states);
    endfunction

    function automatic int k_used();
        return sz_symbols < 1 ? 1 : (sz_symbols > icdfa_pkg::MAX_SYMBOLS ?
                                     icdfa_pkg::MAX_SYMBOLS : sz_symbols);
    endfunction

    task automatic clear_slots();
        for (int p = 0; p < icdfa_pkg::DEPTH; p++) tab[p] = '0;
        for (int i = 0; i < n_used() - 1; i++)
            tab[flag[i] % icdfa_pkg::DEPTH] = icdfa_pkg::SW'(i + 1);
    endtask

    task automatic load_first_table();
        for (int i = 0; i < icdfa_pkg::NF; i++) flag[i] = 0;
        for (int i = 1; i < n_used(); i++) flag[i-1] = k_used() * i - 1;
        clear_slots();
    endtask

    function automatic bit is_full();
        int n, total;
        n = n_used();
        total = n * k_used();
        for (int i = 0; i < n - 2; i++)
            for (int j = flag[i] + 1; j < flag[i+1] && j < total; j++)
                if (tab[j] != icdfa_pkg::SW'(i + 1)) return 1'b0;
        for (int j = flag[n-2] + 1; j < total; j++)
            if (tab[j] != icdfa_pkg::SW'(n - 1)) return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit is_final();
        for (int i = 0; i < n_used() - 1; i++)
            if (flag[i] != i) return 1'b0;
        return is_full();
    endfunction

    task automatic move_flags();
        int i;
        i = n_used() - 2;
        while (i > 0) begin
            if (flag[i] - 1 == flag[i-1]) begin
                flag[i] = k_used() * (i + 1) - 1;
                i--;
            end else begin
                flag[i]--;
                return;
            end
        end
        if (flag[0] > 0) flag[0]--;
    endtask

    task automatic count_slots();
        int top, c, low;
        top = n_used() * k_used() - 1;
        c = n_used() - 2;
        while (c >= -1) begin
            low = c >= 0 ? flag[c] : -1;
            for (int p = top; p > low; p--) begin
                if (p < 0 || p >= icdfa_pkg::DEPTH) continue;
                if (int'(tab[p]) + 1 > c + 1) tab[p] = '0;
                else begin
                    tab[p] = tab[p] + 1'b1;
                    return;
                end
            end
            top = low - 1;
            c--;
        end
    endtask

    task automatic predict_table(input bit rst);
        int total;
        bit full, fin;
        entry_t e;
        if (rst || is_final()) load_first_table();
        else if (is_full()) begin
            move_flags();
            clear_slots();
        end else count_slots();
        total = n_used() * k_used();
        full = is_full();
        fin = is_final();
        for (int p = 0; p < total; p++) begin
            e.idx = icdfa_pkg::AW'(p);
            e.tgt = tab[p];
            e.full = full;
            e.fin = fin;
            e.last = (p == total - 1);
            entry_q = {entry_q, e};
        end
    endtask

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d (entry %0d)", what, got, want, entry_count);
        err_count++;
    endtask

    always @(negedge aclk) begin
        if (entry_count != m_seen) begin
            m_seen = entry_count;
            m_wait = m_idle_on ? $urandom_range(0, 10) : 0;
        end
        m_ready <= (m_wait == 0);
        if (m_valid && m_wait > 0) m_wait--;
    end

    always @(posedge aclk) begin
        entry_t w;
        if (aresetn && m_valid && m_ready) begin
            if (entry_q.size() == 0) report("unexpected item", m_entry_index, -1);
            else begin
                w = entry_q.pop_front();
                if (m_entry_index != w.idx) report("entry_index", m_entry_index, w.idx);
                if (m_target_state != w.tgt) report("target_state", m_target_state, w.tgt);
                if (m_table_full != w.full) report("table_full", m_table_full, w.full);
                if (m_table_final != w.fin) report("table_final", m_table_final, w.fin);
                if (m_run_last != w.last) report("run_last", m_run_last, w.last);
            end
            entry_count++;
        end
    end

    task automatic send_item(input bit rst, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 10) : 0;
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_restart <= rst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_table(rst);
        item_count++;
    endtask

    task automatic hold_input();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic drain();
        hold_input();
        while (entry_q.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [icdfa_pkg::IW-1:0] idx,
                             input logic [icdfa_pkg::CW-1:0] val);
        drain();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == icdfa_pkg::REG_NUM_STATES) sz_states = val;
        else if (idx == icdfa_pkg::REG_NUM_SYMBOLS) sz_symbols = val;
        if (idx == icdfa_pkg::REG_NUM_STATES || idx == icdfa_pkg::REG_NUM_SYMBOLS)
            load_first_table();
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_table();
        send_item(1'b0, 1'b0);
        send_item(1'b1, 1'b0);
        repeat (6) send_item(1'b0, 1'b0);
    endtask

    task automatic test_wrap_small();
        write_reg(icdfa_pkg::REG_NUM_STATES, 4'd2);
        write_reg(icdfa_pkg::REG_NUM_SYMBOLS, 4'd1);
        repeat (6) send_item(1'b0, 1'b0);
        write_reg(icdfa_pkg::REG_NUM_SYMBOLS, 4'd0);
        send_item(1'b0, 1'b0);
        write_reg(icdfa_pkg::REG_NUM_STATES, 4'd0);
        send_item(1'b0, 1'b0);
    endtask

    task automatic test_extremes();
        write_reg(icdfa_pkg::REG_NUM_STATES, 4'd15);
        write_reg(icdfa_pkg::REG_NUM_SYMBOLS, 4'd15);
        send_item(1'b0, 1'b0);
        send_item(1'b1, 1'b0);
        write_reg(icdfa_pkg::REG_NUM_STATES, 4'd8);
        write_reg(icdfa_pkg::REG_NUM_SYMBOLS, 4'd8);
        send_item(1'b0, 1'b0);
        write_reg(8'hFE, 4'd3);
        send_item(1'b0, 1'b0);
    endtask

    task automatic test_random();
        int n_in_phase;
        for (int ph = 0; ph < 12; ph++) begin
            if ($urandom_range(0, 2) == 0)
                write_reg(icdfa_pkg::IW'($urandom_range(2, 255)), 4'($urandom));
            write_reg(icdfa_pkg::REG_NUM_STATES, 4'($urandom_range(2, 4)));
            write_reg(icdfa_pkg::REG_NUM_SYMBOLS, 4'($urandom_range(1, 3)));
            m_idle_on = (ph % 3 != 2);
            n_in_phase = 38;
            for (int i = 0; i < n_in_phase; i++) begin
                send_item($urandom_range(0, 19) == 0, ph % 3 != 2);
                if (i == n_in_phase / 2) begin
                    hold_input();
                    while (entry_q.size() != 0) @(posedge aclk);
                end
            end
        end
        m_idle_on = 1'b1;
    endtask

    initial begin
        err_count = 0;
        cycle_count = 0;
        item_count = 0;
        entry_count = 0;
        m_idle_on = 1'b1;
        sz_states = 4'd2;
        sz_symbols = 4'd2;
        load_first_table();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_table();
        test_wrap_small();
        test_extremes();
        test_random();
        drain();
        $display("covered %0d items, %0d streamed entries, sizes 0..15 incl. wraps",
                 item_count, entry_count);
        if (err_count == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end
endmodule
